>>> rtl/bve_pkg.sv
// shared types, codes and sizes for the bounded vector engine
// no dependencies; imported by bve_cell and bounded_vector_engine_core
package bve_pkg;

  localparam int CAPACITY   = 256;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  localparam int WORD_W     = 32;
  localparam int SCAN_STEPS = IDX_W;
  localparam int STEP_W     = $clog2(SCAN_STEPS);
  localparam int ACT_W      = 3;
  localparam int INDEX_W    = 9;
  localparam int ST_W       = 3;
  localparam int OP_W       = 3;

  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RMF    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RMA    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_INDEX    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  localparam logic [OP_W-1:0] CELL_HOLD   = 3'd0;
  localparam logic [OP_W-1:0] CELL_INSERT = 3'd1;
  localparam logic [OP_W-1:0] CELL_POP    = 3'd2;
  localparam logic [OP_W-1:0] CELL_MARK   = 3'd3;
  localparam logic [OP_W-1:0] CELL_SCAN   = 3'd4;
  localparam logic [OP_W-1:0] CELL_RMF    = 3'd5;
  localparam logic [OP_W-1:0] CELL_SORT   = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic [INDEX_W-1:0]        index;
    logic signed [WORD_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  popped_value;
    logic [CNT_W-1:0]          element_count;
    logic [ST_W-1:0]           status;
  } rsp_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CNT_W-1:0]  tpos;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] value;
    logic              phase;
    logic              any_hit;
  } cell_ctrl_t;

endpackage

>>> rtl/bounded_vector_engine_core.sv
// bounded vector engine: chain of CAPACITY cells, cell 0 holds the last element
// push, pop, insert and clear act in the execute state; remove first match adds a
// prefix scan (one level a cycle) and a removal step; remove all adds an odd-even
// compaction sweep and a count update. one request at a time; a finished beat waits
// in the output register
// reset: count cleared, engine idle, no beat pending; stored words are not cleared
module bounded_vector_engine_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bve_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bve_pkg::rsp_t rsp
);
  import bve_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RMF  = 3'd3;
  localparam logic [2:0] S_SORT = 3'd4;
  localparam logic [2:0] S_RMA  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state;
  req_t              req_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0]  sweep;
  logic [CNT_W-1:0]  hit_total;
  logic [WORD_W-1:0] res_popped;
  logic [WORD_W-1:0] res_popped_next;
  logic [ST_W-1:0]   res_status;
  logic [ST_W-1:0]   res_status_next;
  cell_ctrl_t        ctrl;

  logic [WORD_W-1:0] cell_word  [CAPACITY];
  logic              cell_keep  [CAPACITY];
  logic              cell_incl  [CAPACITY];
  logic              cell_tally [CAPACITY];
  logic              cell_far   [CAPACITY];

  assign req_ready = (state == S_IDLE);

  always_comb begin
    ctrl            = '0;
    ctrl.count      = count;
    ctrl.value      = req_q.value;
    ctrl.phase      = sweep[0];
    ctrl.any_hit    = cell_incl[0];
    count_next      = count;
    res_popped_next = res_popped;
    res_status_next = res_status;
    case (state)
      S_EXEC: begin
        res_popped_next = '0;
        res_status_next = ST_OK;
        case (req_q.action)
          ACT_PUSH: begin
            if (count >= CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end else begin
              ctrl.op    = CELL_INSERT;
              count_next = count + CNT_W'(1);
            end
          end
          ACT_POP: begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
            end else begin
              ctrl.op         = CELL_POP;
              res_popped_next = cell_word[0];
              count_next      = count - CNT_W'(1);
            end
          end
          ACT_INSERT: begin
            if (req_q.index > count) begin
              res_status_next = ST_INDEX;
            end else if (count >= CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end else begin
              ctrl.op    = CELL_INSERT;
              ctrl.tpos  = count - req_q.index;
              count_next = count + CNT_W'(1);
            end
          end
          ACT_RMF, ACT_RMA: begin
            ctrl.op = CELL_MARK;
          end
          ACT_CLEAR: begin
            count_next = '0;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        ctrl.op = CELL_SCAN;
      end
      S_RMF: begin
        ctrl.op = CELL_RMF;
        if (cell_incl[0]) begin
          count_next = count - CNT_W'(1);
        end else begin
          res_status_next = ST_NOTFOUND;
        end
      end
      S_SORT: begin
        ctrl.op = CELL_SORT;
      end
      S_RMA: begin
        if (hit_total == '0) begin
          res_status_next = ST_NOTFOUND;
        end else begin
          count_next = count - hit_total;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count      <= count_next;
      res_popped <= res_popped_next;
      res_status <= res_status_next;
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          step      <= '0;
          sweep     <= '0;
          hit_total <= '0;
          if (req_q.action == ACT_RMF) begin
            state <= S_SCAN;
          end else if (req_q.action == ACT_RMA) begin
            state <= S_SORT;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SCAN_STEPS - 1)) begin
            state <= S_RMF;
          end
        end
        S_RMF: begin
          state <= S_DONE;
        end
        S_SORT: begin
          hit_total <= hit_total + CNT_W'(cell_tally[0]);
          sweep     <= sweep + IDX_W'(1);
          if (sweep == IDX_W'(CAPACITY - 1)) begin
            state <= S_RMA;
          end
        end
        S_RMA: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.popped_value  <= res_popped;
            rsp.element_count <= count;
            rsp.status        <= res_status;
            rsp_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [WORD_W-1:0]     w_below;
    logic [WORD_W-1:0]     w_above;
    logic                  k_below;
    logic                  k_above;
    logic                  i_above;
    logic                  t_above;
    logic [SCAN_STEPS-1:0] far;

    if (j == 0) begin : g_bot
      assign w_below = '0;
      assign k_below = 1'b1;
    end else begin : g_mid_lo
      assign w_below = cell_word[j-1];
      assign k_below = cell_keep[j-1];
    end

    if (j == CAPACITY - 1) begin : g_top
      assign w_above = '0;
      assign k_above = 1'b0;
      assign i_above = 1'b0;
      assign t_above = 1'b0;
    end else begin : g_mid_hi
      assign w_above = cell_word[j+1];
      assign k_above = cell_keep[j+1];
      assign i_above = cell_incl[j+1];
      assign t_above = cell_tally[j+1];
    end

    for (genvar k = 0; k < SCAN_STEPS; k++) begin : g_far
      if (j + (1 << k) < CAPACITY) begin : g_in
        assign far[k] = cell_incl[j + (1 << k)];
      end else begin : g_out
        assign far[k] = 1'b0;
      end
    end
    assign cell_far[j] = far[step];

    bve_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (IDX_W'(j)),
      .word_below  (w_below),
      .word_above  (w_above),
      .keep_below  (k_below),
      .keep_above  (k_above),
      .incl_above  (i_above),
      .incl_far    (cell_far[j]),
      .tally_above (t_above),
      .word        (cell_word[j]),
      .keep        (cell_keep[j]),
      .incl        (cell_incl[j]),
      .tally       (cell_tally[j])
    );
  end

endmodule

>>> rtl/bve_cell.sv
// one storage cell of the chain: a word plus keep, scan and tally flags
// depends on bve_pkg
module bve_cell (
  input  logic                       clk,
  input  bve_pkg::cell_ctrl_t        ctrl,
  input  logic [bve_pkg::IDX_W-1:0]  pos,
  input  logic [bve_pkg::WORD_W-1:0] word_below,
  input  logic [bve_pkg::WORD_W-1:0] word_above,
  input  logic                       keep_below,
  input  logic                       keep_above,
  input  logic                       incl_above,
  input  logic                       incl_far,
  input  logic                       tally_above,
  output logic [bve_pkg::WORD_W-1:0] word,
  output logic                       keep,
  output logic                       incl,
  output logic                       tally
);
  import bve_pkg::*;

  logic [CNT_W-1:0] pos_ext;
  logic             live;
  logic             hit;
  logic             lower;

  assign pos_ext = {1'b0, pos};
  assign live    = (pos_ext < ctrl.count);
  assign hit     = live && (word == ctrl.value);
  assign lower   = (pos[0] == ctrl.phase);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (pos_ext > ctrl.tpos) begin
          word <= word_below;
        end else if (pos_ext == ctrl.tpos) begin
          word <= ctrl.value;
        end
      end
      CELL_POP: begin
        word <= word_above;
      end
      CELL_MARK: begin
        keep  <= live && !hit;
        incl  <= hit;
        tally <= hit;
      end
      CELL_SCAN: begin
        incl <= incl | incl_far;
      end
      CELL_RMF: begin
        if (ctrl.any_hit && !incl_above) begin
          word <= word_above;
        end
      end
      CELL_SORT: begin
        tally <= tally_above;
        if (lower) begin
          if (!keep && keep_above) begin
            word <= word_above;
            keep <= 1'b1;
          end
        end else begin
          if (keep && !keep_below) begin
            keep <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
